[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Holds the queue depth, field widths, command and status codes, and the
// structs that pass between the cell chain and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int TAG_W = 16;
  localparam int WGT_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TOT_W = 5;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored entry
  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [WGT_W-1:0] weight;
  } entry_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic   shift_in;
    logic   shift_out;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

[rtl/spq_in_if.sv]
// ----------------------------------------------------------------------------
// spq_in_if: command channel of the sorted priority queue
// Valid/ready channel carrying one command word: insert or remove.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [spq_pkg::TAG_W-1:0]           new_tag;
  logic signed [spq_pkg::WGT_W-1:0]    new_weight;

  modport source (output valid, output cmd, output new_tag, output new_weight,
                  input ready);
  modport sink   (input valid, input cmd, input new_tag, input new_weight,
                  output ready);
endinterface

[rtl/spq_out_if.sv]
// ----------------------------------------------------------------------------
// spq_out_if: result channel of the sorted priority queue
// Valid/ready channel carrying one result word per command.
// ----------------------------------------------------------------------------
interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::TAG_W-1:0]           removed_tag;
  logic signed [spq_pkg::WGT_W-1:0]    removed_weight;
  logic [spq_pkg::TAG_W-1:0]           head_tag;
  logic signed [spq_pkg::WGT_W-1:0]    head_weight;
  logic                                head_valid;
  logic [spq_pkg::TOT_W-1:0]           entry_total;
  logic [1:0]                          status;

  modport source (output valid, output removed_tag, output removed_weight,
                  output head_tag, output head_weight, output head_valid,
                  output entry_total, output status, input ready);
  modport sink   (input valid, input removed_tag, input removed_weight,
                  input head_tag, input head_weight, input head_valid,
                  input entry_total, input status, output ready);
endinterface

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted priority queue
// Holds one entry. On insert it keeps its entry, takes the new entry or takes
// its left neighbor's entry; on remove it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  logic              left_ge,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  output logic              ge,
  output spq_pkg::entry_t   entry,
  output spq_pkg::entry_t   entry_next
);
  import spq_pkg::*;

  // Stored entry stays ahead of the new one on equal or greater weight
  assign ge = occ && ($signed(entry.weight) >= $signed(ctl.new_entry.weight));

  // Select keep, new entry, or neighbor
  always_comb begin
    entry_next = entry;
    if (ctl.shift_in) begin
      if (ge) begin
        entry_next = entry;
      end else if (left_ge) begin
        entry_next = ctl.new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctl.shift_out) begin
      entry_next = right_entry;
    end
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted max-priority queue on a chain of cells
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    cmd, new_tag, new_weight
//   out_ch   out  valid/ready    removed_tag/weight, head_tag/weight,
//                                head_valid, entry_total, status
//
// One command per cycle while in_ch.ready is high: all cells compare
// against the new weight and shift in the same edge that accepts the word,
// which also registers the result word. in_ch.ready drops only while a
// result waits there and out_ch.ready is low. Reset clears the entry count
// and the output valid; the slot contents need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input logic      clk,
  input logic      rst,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid;
  logic             out_valid_next;

  logic      accept;
  logic      is_remove;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;
  status_t   status_next;

  entry_t cell_entry [DEPTH];
  entry_t cell_next  [DEPTH];
  logic   cell_ge    [DEPTH];

  entry_t removed_next;
  entry_t head_next;

  // Handshake on the command side
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_remove   = (in_ch.cmd == CMD_REMOVE);
  assign full        = (count == CNT_W'(DEPTH));
  assign empty       = (count == '0);

  // Broadcast control to the chain
  always_comb begin
    ctl.shift_in         = accept && !is_remove && !full;
    ctl.shift_out        = accept && is_remove && !empty;
    ctl.new_entry.tag    = in_ch.new_tag;
    ctl.new_entry.weight = in_ch.new_weight;
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_entry = '0;
    end else begin : g_inner
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (cell_ge[i]),
      .entry       (cell_entry[i]),
      .entry_next  (cell_next[i])
    );
  end

  // Advance the entry count and pick the status
  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    priority if (accept && is_remove && empty) begin
      status_next = ST_EMPTY;
    end else if (accept && !is_remove && full) begin
      status_next = ST_FULL;
    end else if (ctl.shift_in) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.shift_out) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Build the result word
  assign removed_next = ctl.shift_out ? cell_entry[0] : '0;
  assign head_next    = (count_next != '0) ? cell_next[0] : '0;

  // Output valid
  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Hold the result word until the next accepted command
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.removed_tag    <= removed_next.tag;
      out_ch.removed_weight <= removed_next.weight;
      out_ch.head_tag       <= head_next.tag;
      out_ch.head_weight    <= head_next.weight;
      out_ch.head_valid     <= (count_next != '0);
      out_ch.entry_total    <= TOT_W'(count_next);
      out_ch.status         <= status_next;
    end
  end

  assign out_ch.valid = out_valid;

  // Count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // A successful insert grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.shift_in |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  // Head stays ordered ahead of the second slot
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |->
      $signed(cell_entry[0].weight) >= $signed(cell_entry[1].weight))
    else $error("head weight below second slot");

endmodule

[test/sorted_priority_queue_tb.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// Drives insert and remove words through the command channel and checks each
// result word against a shadow copy of the sorted store kept in the bench.
// Covers empty removes, full inserts, extreme and tied weights, and long
// random fill and drain runs, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  import spq_pkg::*;

  // One result word as the bench expects it
  typedef struct packed {
    logic [TAG_W-1:0]        removed_tag;
    logic signed [WGT_W-1:0] removed_weight;
    logic [TAG_W-1:0]        head_tag;
    logic signed [WGT_W-1:0] head_weight;
    logic                    head_valid;
    logic [TOT_W-1:0]        entry_total;
    status_t                 status;
  } result_t;

  logic clk;
  logic rst;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the sorted store
  logic [TAG_W-1:0]        shadow_tag [DEPTH];
  logic signed [WGT_W-1:0] shadow_weight [DEPTH];
  int                      shadow_count;

  result_t pending_results[$];

  bit idle_on;
  int error_count;
  int checked_count;
  int insert_count;
  int remove_count;
  int full_drop_count;
  int empty_drop_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    repeat (200000) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Apply one command to the shadow store and return the word it must produce
  function automatic result_t apply_queue_cmd(logic cmd, logic [TAG_W-1:0] tag,
                                              logic signed [WGT_W-1:0] weight);
    result_t r;
    int      pos;
    int      i;
    r        = '0;
    r.status = ST_DONE;
    if (cmd == CMD_REMOVE) begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_tag    = shadow_tag[0];
        r.removed_weight = shadow_weight[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_tag[i-1]    = shadow_tag[i];
          shadow_weight[i-1] = shadow_weight[i];
        end
        shadow_count--;
      end
    end else begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // place behind every entry of equal or greater weight
        pos = 0;
        while (pos < shadow_count && shadow_weight[pos] >= weight) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_tag[i]    = shadow_tag[i-1];
          shadow_weight[i] = shadow_weight[i-1];
        end
        shadow_tag[pos]    = tag;
        shadow_weight[pos] = weight;
        shadow_count++;
      end
    end
    if (shadow_count > 0) begin
      r.head_tag    = shadow_tag[0];
      r.head_weight = shadow_weight[0];
      r.head_valid  = 1'b1;
    end
    r.entry_total = TOT_W'(shadow_count);
    return r;
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Send one command word; predict its result on acceptance
  task automatic send_word(logic cmd, logic [TAG_W-1:0] tag,
                           logic signed [WGT_W-1:0] weight);
    result_t r;
    // idle at random before the word
    while (idle_on && $urandom_range(99) < 30) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.cmd        = cmd;
    in_ch.new_tag    = tag;
    in_ch.new_weight = weight;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_queue_cmd(cmd, tag, weight);
    pending_results.push_back(r);
    if (cmd == CMD_REMOVE) remove_count++;
    else insert_count++;
    if (r.status == ST_FULL) full_drop_count++;
    if (r.status == ST_EMPTY) empty_drop_count++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Weights: extremes, a narrow band for ties, and the full range
  function automatic logic signed [WGT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return WGT_W'(int'($urandom_range(4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  // Drive result ready with random stalls
  always @(negedge clk) begin
    if (idle_on) out_ch.ready = ($urandom_range(99) >= 30);
    else out_ch.ready = 1'b1;
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: head %h/%0d total %0d status %0d",
                               out_ch.head_tag, out_ch.head_weight,
                               out_ch.entry_total, out_ch.status));
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_ch.removed_tag !== want.removed_tag ||
            out_ch.removed_weight !== want.removed_weight ||
            out_ch.head_tag !== want.head_tag ||
            out_ch.head_weight !== want.head_weight ||
            out_ch.head_valid !== want.head_valid ||
            out_ch.entry_total !== want.entry_total ||
            out_ch.status !== want.status) begin
          report_error($sformatf({"mismatch: expected rm %h/%0d head %h/%0d v%0d ",
                                  "n%0d st%0d, got rm %h/%0d head %h/%0d v%0d n%0d st%0d"},
                                 want.removed_tag, want.removed_weight,
                                 want.head_tag, want.head_weight, want.head_valid,
                                 want.entry_total, want.status,
                                 out_ch.removed_tag, out_ch.removed_weight,
                                 out_ch.head_tag, out_ch.head_weight,
                                 out_ch.head_valid, out_ch.entry_total,
                                 out_ch.status));
        end
      end
    end
  end

  // Removes on an empty store are dropped and flagged
  task automatic test_remove_on_empty();
    send_word(CMD_REMOVE, 16'hFFFF, 32'sh7FFF_FFFF);
    send_word(CMD_REMOVE, 16'h0000, 32'sh0000_0000);
  endtask

  // Fill the store with extreme and tied weights
  task automatic test_fill_with_extremes();
    send_word(CMD_INSERT, 16'h0001, 32'sh7FFF_FFFF);
    send_word(CMD_INSERT, 16'hFFFF, 32'sh8000_0000);
    send_word(CMD_INSERT, 16'h0000, 32'sh0000_0000);
    send_word(CMD_INSERT, 16'h00F0, -32'sd1);
    send_word(CMD_INSERT, 16'h0F00, 32'sd1);
    send_word(CMD_INSERT, 16'h0002, 32'sh7FFF_FFFF);
    send_word(CMD_INSERT, 16'hFFFE, 32'sh8000_0000);
    send_word(CMD_INSERT, 16'h00F1, -32'sd1);
    send_word(CMD_INSERT, 16'h0003, 32'sh0000_0000);
    send_word(CMD_INSERT, 16'hAAAA, 32'sh4000_0000);
    send_word(CMD_INSERT, 16'h5555, -32'sh4000_0000);
    send_word(CMD_INSERT, 16'h8000, 32'sh7FFF_FFFE);
    send_word(CMD_INSERT, 16'h7FFF, 32'sh8000_0001);
    send_word(CMD_INSERT, 16'h0004, 32'sh7FFF_FFFF);
    send_word(CMD_INSERT, 16'h1234, 32'sh5555_5555);
    send_word(CMD_INSERT, 16'hEDCB, 32'shAAAA_AAAA);
  endtask

  // Inserts into a full store are dropped; a freed slot takes one more
  task automatic test_insert_when_full();
    send_word(CMD_INSERT, 16'hBEEF, 32'sh7FFF_FFFF);
    send_word(CMD_REMOVE, 16'h0000, 32'sh0000_0000);
    send_word(CMD_INSERT, 16'h0005, 32'sh7FFF_FFFF);
    send_word(CMD_INSERT, 16'hCAFE, 32'sh8000_0000);
  endtask

  // Take a few entries off the head, ties leaving in arrival order
  task automatic test_partial_drain();
    repeat (3) send_word(CMD_REMOVE, TAG_W'($urandom_range(65535)), $urandom);
  endtask

  // Hold the command channel until every result is back
  task automatic test_hold_until_idle();
    stop_sending();
    wait_for_results();
    @(negedge clk);
  endtask

  // Alternate fill-heavy and drain-heavy bursts so the store swings between
  // empty and full
  task automatic test_random_traffic(int n_items, bit with_idle);
    int  left;
    int  burst;
    bit  filling;
    logic cmd;
    idle_on = with_idle;
    left    = n_items;
    filling = (shadow_count < DEPTH / 2);
    while (left > 0) begin
      burst = $urandom_range(18, 40);
      while (burst > 0 && left > 0) begin
        if (filling) cmd = ($urandom_range(99) < 80) ? CMD_INSERT : CMD_REMOVE;
        else cmd = ($urandom_range(99) < 80) ? CMD_REMOVE : CMD_INSERT;
        send_word(cmd, TAG_W'($urandom_range(65535)), pick_weight());
        burst--;
        left--;
      end
      filling = !filling;
    end
    idle_on = 1'b1;
  endtask

  // Main sequence
  initial begin
    rst              = 1'b1;
    idle_on          = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_INSERT;
    in_ch.new_tag    = '0;
    in_ch.new_weight = '0;
    shadow_count     = 0;
    error_count      = 0;
    checked_count    = 0;
    insert_count     = 0;
    remove_count     = 0;
    full_drop_count  = 0;
    empty_drop_count = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_remove_on_empty();
    test_fill_with_extremes();
    test_insert_when_full();
    test_partial_drain();
    test_hold_until_idle();
    test_random_traffic(200, 1'b1);
    test_hold_until_idle();
    test_random_traffic(150, 1'b0);
    test_hold_until_idle();
    test_random_traffic(200, 1'b1);
    stop_sending();

    // drain and watch for stray words
    wait_for_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("Summary: %0d inserts, %0d removes, %0d result words checked",
             insert_count, remove_count, checked_count);
    $display("Summary: %0d inserts dropped when full, %0d removes on empty, %0d errors",
             full_drop_count, empty_drop_count, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sorted_priority_queue.f]
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
